>>> rtl/core/psu_pkg.sv
// ---------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared widths, codes and types of the gray scanline unfilter block.
// ---------------------------------------------------------------------------
package psu_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_BPP   = 4;
    localparam int MAX_HEIGHT    = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int BPP_W      = 3;
    localparam int DIM_W      = 13;
    localparam int SUM_W      = 10;

    // Multiplying by 683 and dropping 11 bits divides any sum up to 765 by three.
    localparam int RECIP_THREE = 683;
    localparam int RECIP_SHIFT = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BPP    = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } filter_t;

    typedef enum logic [1:0] {
        SUM_HOLD = 2'd0,
        SUM_ADD  = 2'd1,
        SUM_LOAD = 2'd2
    } sum_op_t;

    typedef struct packed {
        logic    is_filter;
        logic    use_up;
        logic    has_left;
        sum_op_t sum_op;
        logic    pix_end;
        logic    row_end;
        logic    img_end;
        logic    avg;
    } word_ctl_t;

endpackage

>>> rtl/core/psu_if.sv
// ---------------------------------------------------------------------------
// PNG scanline unfilter channels
// Valid/ready channels for scanline bytes, gray pixels and register writes.
// ---------------------------------------------------------------------------
interface psu_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_image;

    modport source (output valid, output data_byte, output start_of_image, input ready);
    modport sink (input valid, input data_byte, input start_of_image, output ready);
endinterface

interface psu_gray_if;
    logic       valid;
    logic       ready;
    logic [7:0] gray_value;
    logic       end_of_row;
    logic       end_of_image;

    modport source (output valid, output gray_value, output end_of_row, output end_of_image,
                    input ready);
    modport sink (input valid, input gray_value, input end_of_row, input end_of_image,
                  output ready);
endinterface

interface psu_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [psu_pkg::CFG_IDX_W-1:0]     index;
    logic [psu_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/psu_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/psu_recon.sv
// ---------------------------------------------------------------------------
// PNG byte reconstruction
// Applies the None, Sub, Up, Average or Paeth predictor to one filtered byte.
// ---------------------------------------------------------------------------
module psu_recon (
    input  logic [7:0] filter_code,
    input  logic [7:0] data_byte,
    input  logic [7:0] left,
    input  logic [7:0] up,
    input  logic [7:0] up_left,
    output logic [7:0] value
);
    import psu_pkg::*;

    logic signed [10:0] pa;
    logic signed [10:0] pb;
    logic signed [10:0] pc;
    logic [10:0]        abs_a;
    logic [10:0]        abs_b;
    logic [10:0]        abs_c;
    logic [7:0]         paeth;
    logic [8:0]         avg_sum;
    logic [7:0]         pred;

    always_comb
    begin
        pa = $signed({3'b000, up}) - $signed({3'b000, up_left});
        pb = $signed({3'b000, left}) - $signed({3'b000, up_left});
        pc = pa + pb;
        abs_a = pa[10] ? 11'(-pa) : 11'(pa);
        abs_b = pb[10] ? 11'(-pb) : 11'(pb);
        abs_c = pc[10] ? 11'(-pc) : 11'(pc);
        if ((abs_a <= abs_b) && (abs_a <= abs_c))
        begin
            paeth = left;
        end
        else if (abs_b <= abs_c)
        begin
            paeth = up;
        end
        else
        begin
            paeth = up_left;
        end

        avg_sum = {1'b0, left} + {1'b0, up};

        if (filter_code[7:3] != 5'd0)
        begin
            pred = 8'd0;
        end
        else
        begin
            case (filter_t'(filter_code[2:0]))
                FLT_SUB:   pred = left;
                FLT_UP:    pred = up;
                FLT_AVG:   pred = avg_sum[8:1];
                FLT_PAETH: pred = paeth;
                default:   pred = 8'd0;
            endcase
        end

        value = data_byte + pred;
    end

endmodule

>>> rtl/core/png_scanline_unfilter_gray_unit.sv
// ---------------------------------------------------------------------------
// PNG scanline unfilter with gray output
// Rebuilds 8-bit PNG rows from the inflated byte stream and emits one gray
// level per completed pixel, keeping the previous row in a line store.
//
//   Port   Direction  Word
//   scan   in         data_byte, start_of_image
//   gray   out        gray_value, end_of_row, end_of_image
//   cfg    in         index, data (bytes per pixel, width, height)
//
// One byte is taken every cycle unless the output stalls the second stage.
// The first stage tracks the row position and issues the line store read, the
// second stage reconstructs the byte and writes it back to the store.
// A stalled output holds the second stage and then the input; the output
// register lets a new byte in while a pixel waits to be taken.
// Reset clears the control state; the line store is not cleared.
// ---------------------------------------------------------------------------
module png_scanline_unfilter_gray_unit #(
    parameter int MAX_WIDTH = psu_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BPP   = psu_pkg::DEF_MAX_BPP
) (
    input  logic         clk,
    input  logic         rst_n,
    psu_scan_if.sink     scan,
    psu_gray_if.source   gray,
    psu_cfg_if.sink      cfg
);
    import psu_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_BPP;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W = $clog2(DEPTH + 1);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int WCMP_W = (WID_W > DIM_W) ? WID_W : DIM_W;
    localparam int SEL_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

    logic [BPP_W-1:0] cfg_bpp_reg;
    logic [DIM_W-1:0] cfg_width_reg;
    logic [DIM_W-1:0] cfg_height_reg;

    logic [BPP_W-1:0]  bpp_eff;
    logic [WCMP_W-1:0] width_ext;
    logic [WCMP_W-1:0] width_eff;
    logic [DIM_W-1:0]  height_eff;
    logic [POS_W-1:0]  stride;
    logic [SEL_W-1:0]  byte_sel;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [1:0]       chan_reg;
    logic [1:0]       chan_next;
    logic [DIM_W-1:0] row_reg;
    logic [DIM_W-1:0] row_next;
    logic [POS_W-1:0] x_pos;
    word_ctl_t        ctl;
    logic             scan_fire;

    logic             s1_valid_reg;
    word_ctl_t        s1_ctl_reg;
    logic [7:0]       s1_byte_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic             s1_go;

    logic [7:0]               filter_reg;
    logic [MAX_BPP-1:0][7:0]  left_reg;
    logic [MAX_BPP-1:0][7:0]  left_next;
    logic [MAX_BPP-1:0][7:0]  upper_reg;
    logic [MAX_BPP-1:0][7:0]  upper_next;
    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         sum_new;

    logic [7:0] ram_rdata;
    logic [7:0] nb_left;
    logic [7:0] nb_up;
    logic [7:0] nb_up_left;
    logic [7:0] recon_value;

    logic             out_valid_reg;
    logic [SUM_W-1:0] out_sum_reg;
    logic             out_avg_reg;
    logic             out_eor_reg;
    logic             out_eoi_reg;
    logic [2*SUM_W-1:0] third;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_bpp_reg    <= BPP_W'(1);
            cfg_width_reg  <= DIM_W'(1);
            cfg_height_reg <= DIM_W'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_BPP:    cfg_bpp_reg    <= cfg.data[BPP_W-1:0];
                CFG_WIDTH:  cfg_width_reg  <= cfg.data[DIM_W-1:0];
                CFG_HEIGHT: cfg_height_reg <= cfg.data[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (cfg_bpp_reg == '0)
        begin
            bpp_eff = BPP_W'(1);
        end
        else if (cfg_bpp_reg > BPP_W'(MAX_BPP))
        begin
            bpp_eff = BPP_W'(MAX_BPP);
        end
        else
        begin
            bpp_eff = cfg_bpp_reg;
        end

        width_ext = WCMP_W'(cfg_width_reg);
        if (width_ext == '0)
        begin
            width_eff = WCMP_W'(1);
        end
        else if (width_ext > WCMP_W'(MAX_WIDTH))
        begin
            width_eff = WCMP_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end

        if (cfg_height_reg == '0)
        begin
            height_eff = DIM_W'(1);
        end
        else if (cfg_height_reg > DIM_W'(MAX_HEIGHT))
        begin
            height_eff = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = cfg_height_reg;
        end

        stride = POS_W'(POS_W'(width_eff) * POS_W'(bpp_eff));
        byte_sel = SEL_W'(bpp_eff - BPP_W'(1));
    end

    // The position counter runs ahead of reconstruction so that the line store
    // read for a byte is issued when the byte is taken.
    assign s1_go = s1_valid_reg && (!s1_ctl_reg.pix_end || !out_valid_reg || gray.ready);
    assign scan.ready = !s1_valid_reg || s1_go;
    assign scan_fire = scan.valid && scan.ready;
    assign x_pos = pos_reg - POS_W'(1);

    always_comb
    begin
        pos_next = pos_reg;
        chan_next = chan_reg;
        row_next = row_reg;
        ctl = '0;
        ctl.use_up = (row_reg != '0);
        ctl.has_left = (x_pos >= POS_W'(bpp_eff));
        ctl.avg = (bpp_eff >= BPP_W'(3));
        ctl.row_end = (pos_reg >= stride);
        ctl.pix_end = (({1'b0, chan_reg} + 3'd1) >= bpp_eff) || ctl.row_end;
        ctl.img_end = ({1'b0, row_reg} + (DIM_W + 1)'(1)) >= {1'b0, height_eff};
        if (ctl.avg)
        begin
            ctl.sum_op = (chan_reg < 2'd3) ? SUM_ADD : SUM_HOLD;
        end
        else
        begin
            ctl.sum_op = (chan_reg == 2'd0) ? SUM_LOAD : SUM_HOLD;
        end

        if (scan.start_of_image || (pos_reg == '0))
        begin
            ctl.is_filter = 1'b1;
            ctl.pix_end = 1'b0;
            ctl.row_end = 1'b0;
            ctl.img_end = 1'b0;
            pos_next = POS_W'(1);
            chan_next = 2'd0;
            if (scan.start_of_image)
            begin
                row_next = '0;
            end
        end
        else if (!ctl.pix_end)
        begin
            chan_next = chan_reg + 2'd1;
            pos_next = pos_reg + POS_W'(1);
        end
        else
        begin
            chan_next = 2'd0;
            if (ctl.row_end)
            begin
                pos_next = '0;
                row_next = ctl.img_end ? '0 : row_reg + DIM_W'(1);
            end
            else
            begin
                ctl.img_end = 1'b0;
                pos_next = pos_reg + POS_W'(1);
            end
        end
        if (!ctl.row_end)
        begin
            ctl.img_end = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            chan_reg <= 2'd0;
            row_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (scan_fire)
            begin
                pos_reg <= pos_next;
                chan_reg <= chan_next;
                row_reg <= row_next;
            end
            if (scan.ready)
            begin
                s1_valid_reg <= scan.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_fire)
        begin
            s1_ctl_reg <= ctl;
            s1_byte_reg <= scan.data_byte;
            s1_addr_reg <= x_pos[ADDR_W-1:0];
        end
    end

    psu_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_row_store (
        .clk(clk),
        .we(s1_go && !s1_ctl_reg.is_filter),
        .waddr(s1_addr_reg),
        .wdata(recon_value),
        .re(scan_fire && !ctl.is_filter),
        .raddr(x_pos[ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    assign nb_left = s1_ctl_reg.has_left ? left_reg[byte_sel] : 8'd0;
    assign nb_up = s1_ctl_reg.use_up ? ram_rdata : 8'd0;
    assign nb_up_left = (s1_ctl_reg.use_up && s1_ctl_reg.has_left) ? upper_reg[byte_sel] : 8'd0;

    psu_recon u_recon (
        .filter_code(filter_reg),
        .data_byte(s1_byte_reg),
        .left(nb_left),
        .up(nb_up),
        .up_left(nb_up_left),
        .value(recon_value)
    );

    always_comb
    begin
        for (int i = MAX_BPP - 1; i > 0; i--)
        begin
            left_next[i] = left_reg[i-1];
            upper_next[i] = upper_reg[i-1];
        end
        left_next[0] = recon_value;
        upper_next[0] = nb_up;

        case (s1_ctl_reg.sum_op)
            SUM_ADD:  sum_new = sum_reg + SUM_W'(recon_value);
            SUM_LOAD: sum_new = SUM_W'(recon_value);
            default:  sum_new = sum_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= 8'd0;
            left_reg <= '0;
            upper_reg <= '0;
            sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_go)
            begin
                if (s1_ctl_reg.is_filter)
                begin
                    filter_reg <= s1_byte_reg;
                    left_reg <= '0;
                    upper_reg <= '0;
                    sum_reg <= '0;
                end
                else
                begin
                    left_reg <= left_next;
                    upper_reg <= upper_next;
                    sum_reg <= s1_ctl_reg.pix_end ? '0 : sum_new;
                end
            end
            if (s1_go && s1_ctl_reg.pix_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (gray.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_ctl_reg.pix_end)
        begin
            out_sum_reg <= sum_new;
            out_avg_reg <= s1_ctl_reg.avg;
            out_eor_reg <= s1_ctl_reg.row_end;
            out_eoi_reg <= s1_ctl_reg.img_end;
        end
    end

    assign third = out_sum_reg * SUM_W'(RECIP_THREE);
    assign gray.valid = out_valid_reg;
    assign gray.gray_value = out_avg_reg ? third[RECIP_SHIFT+7:RECIP_SHIFT] : out_sum_reg[7:0];
    assign gray.end_of_row = out_eor_reg;
    assign gray.end_of_image = out_eoi_reg;

endmodule
